// ----- hw/rtl/rfa_pkg.sv -----
`timescale 1ns / 1ps

package rfa_pkg;

   // field widths
   localparam int COORD_W = 12;
   localparam int SIDE_W  = 13;
   localparam int ALPHA_W = 8;

   localparam int MAX_SIDE   = 4096;
   localparam int SIDE_RESET = 256;

   // Q0.16 fractions, 1.0 needs one more bit
   localparam int FRAC_W = 16;
   localparam int QONE_W = FRAC_W + 1;

   // datapath widths
   localparam int SQ_W   = 2 * (SIDE_W - 1) + 1;  // one squared distance or side squared
   localparam int DIV_W  = SQ_W + 1;              // numerator, denominator, remainder
   localparam int QUO_W  = 2 * FRAC_W + 1;        // quotient bits of s * 2^32 / den
   localparam int RAD_W  = QUO_W + 1;             // radicand padded to an even width
   localparam int ROOT_W = QONE_W;
   localparam int SRM_W  = ROOT_W + 4;            // root remainder

   // pipeline layout
   localparam int DIV_STEPS     = QUO_W;
   localparam int DIV_PER_STAGE = 4;
   localparam int DIV_STAGES    = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

   localparam int SQRT_STEPS     = RAD_W / 2;
   localparam int SQRT_PER_STAGE = 4;
   localparam int SQRT_STAGES    = (SQRT_STEPS + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;

   localparam int ST_FRONT  = 0;
   localparam int ST_SQUARE = 1;
   localparam int ST_SUM    = 2;
   localparam int ST_DIV0   = 3;
   localparam int ST_SQRT0  = ST_DIV0 + DIV_STAGES;
   localparam int ST_PW2    = ST_SQRT0 + SQRT_STAGES;
   localparam int ST_PW4    = ST_PW2 + 1;
   localparam int ST_PW8    = ST_PW4 + 1;
   localparam int ST_PW10   = ST_PW8 + 1;
   localparam int ST_ALPHA  = ST_PW10 + 1;
   localparam int NUM_STAGES = ST_ALPHA + 1;

   typedef struct packed {
      logic [SIDE_W-1:0] abs_x;
      logic [SIDE_W-1:0] abs_y;
      logic [SIDE_W-1:0] side;
   } front_type;

   typedef struct packed {
      logic [SQ_W-1:0] sq_x;
      logic [SQ_W-1:0] sq_y;
      logic [SQ_W-1:0] side_sq;
   } square_type;

   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [DIV_W-1:0] den;
      logic [QUO_W-1:0] quo;
   } div_type;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [SRM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [QONE_W-1:0] pw;
      logic [QONE_W-1:0] a2;
   } power_type;

endpackage

// ----- hw/rtl/rfa_if.sv -----
`timescale 1ns / 1ps

interface rfa_req_if import rfa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] pixel_x;
   logic [COORD_W-1:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface rfa_rsp_if import rfa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ALPHA_W-1:0] alpha;

   modport source (output valid, output alpha, input ready);
   modport sink   (input valid, input alpha, output ready);
endinterface

interface rfa_csr_if import rfa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SIDE_W-1:0] texture_side;

   modport source (output valid, output texture_side, input ready);
   modport sink   (input valid, input texture_side, output ready);
endinterface

// ----- hw/rtl/radial_falloff_alpha_top.sv -----
`timescale 1ns / 1ps

// Channel    Dir  Payload                      Transaction
// req_bus    in   pixel_x[11:0], pixel_y[11:0] valid & ready
// rsp_bus    out  alpha[7:0]                   valid & ready
// csr_bus    in   texture_side[12:0]           valid & ready (always ready)
//
// One transaction per cycle in, one per cycle out while rsp_bus is ready;
// the path runs through the 33-bit fraction divider (9 stages, up to 4 bits
// each), the 17-bit square root (5 stages) and the squarings with the alpha scale (5 stages).
// Synchronous active-high reset empties the pipeline and sets the side to 256.
// Each stage holds only while it is full and the stage after it holds, so
// bubbles close up and a stalled output still lets new transactions in.

module radial_falloff_alpha_top import rfa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   rfa_req_if.sink     req_bus,
   rfa_rsp_if.source   rsp_bus,
   rfa_csr_if.sink     csr_bus
);

   // ------------------------------------------------------------------
   // functions
   // ------------------------------------------------------------------

   // Restoring division steps: step 0 compares the bare numerator, every
   // later step shifts the remainder first.
   function automatic div_type div_steps(input div_type v, input int first);
      div_type          r;
      logic [DIV_W-1:0] trial;
      logic             take;
      r = v;
      for (int j = 0; j < DIV_PER_STAGE; j++) begin
         if (first + j < DIV_STEPS) begin
            trial = (first + j == 0) ? r.rem : {r.rem[DIV_W-2:0], 1'b0};
            take  = (trial >= r.den);
            r.rem = take ? (trial - r.den) : trial;
            r.quo = {r.quo[QUO_W-2:0], take};
         end
      end
      return r;
   endfunction

   // Digit-by-digit square root, two radicand bits per step.
   function automatic sqrt_type sqrt_steps(input sqrt_type v, input int first);
      sqrt_type         r;
      logic [SRM_W-1:0] trial;
      int               k;
      r = v;
      for (int j = 0; j < SQRT_PER_STAGE; j++) begin
         k = first + j;
         if (k < SQRT_STEPS) begin
            r.rem = {r.rem[SRM_W-3:0], r.rad[RAD_W-1-2*k -: 2]};
            trial = {2'b00, r.root, 2'b01};
            if (r.rem >= trial) begin
               r.rem  = r.rem - trial;
               r.root = {r.root[ROOT_W-2:0], 1'b1};
            end else begin
               r.root = {r.root[ROOT_W-2:0], 1'b0};
            end
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // configuration register
   // ------------------------------------------------------------------
   logic [SIDE_W-1:0] texture_side_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         texture_side_ff <= SIDE_W'(SIDE_RESET);
      end else if (csr_bus.valid) begin
         texture_side_ff <= csr_bus.texture_side;
      end
   end

   // ------------------------------------------------------------------
   // pipeline control: a stage loads when it is empty or its successor loads
   // ------------------------------------------------------------------
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] stage_ready;

   always_comb begin
      stage_ready[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_bus.ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         stage_ready[i] = !valid_ff[i] || stage_ready[i+1];
      end
   end

   assign valid_in      = {valid_ff[NUM_STAGES-2:0], req_bus.valid};
   assign req_bus.ready = stage_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            if (stage_ready[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // front: sanitise the side, clamp the coordinates, form |2c - side|
   // ------------------------------------------------------------------
   front_type         front_ff;
   front_type         front_in;
   logic [SIDE_W-1:0] side_eff;
   logic [SIDE_W-1:0] x_c;
   logic [SIDE_W-1:0] y_c;
   logic [SIDE_W-1:0] x2;
   logic [SIDE_W-1:0] y2;

   always_comb begin
      if (texture_side_ff == '0) begin
         side_eff = SIDE_W'(1);
      end else if (texture_side_ff > SIDE_W'(MAX_SIDE)) begin
         side_eff = SIDE_W'(MAX_SIDE);
      end else begin
         side_eff = texture_side_ff;
      end

      // clamp coordinates at or beyond the side to side - 1
      x_c = {1'b0, req_bus.pixel_x};
      y_c = {1'b0, req_bus.pixel_y};
      if (x_c >= side_eff) x_c = side_eff - SIDE_W'(1);
      if (y_c >= side_eff) y_c = side_eff - SIDE_W'(1);

      // doubled coordinates keep the half-pixel centre exact
      x2 = {x_c[COORD_W-1:0], 1'b0};
      y2 = {y_c[COORD_W-1:0], 1'b0};

      front_in.abs_x = (x2 >= side_eff) ? (x2 - side_eff) : (side_eff - x2);
      front_in.abs_y = (y2 >= side_eff) ? (y2 - side_eff) : (side_eff - y2);
      front_in.side  = side_eff;
   end

   always_ff @(posedge clock) begin
      if (stage_ready[ST_FRONT]) front_ff <= front_in;
   end

   // ------------------------------------------------------------------
   // squares: three parallel 13x13 products
   // ------------------------------------------------------------------
   square_type          square_ff;
   square_type          square_in;
   logic [2*SIDE_W-1:0] prod_x;
   logic [2*SIDE_W-1:0] prod_y;
   logic [2*SIDE_W-1:0] prod_s;

   always_comb begin
      prod_x = front_ff.abs_x * front_ff.abs_x;
      prod_y = front_ff.abs_y * front_ff.abs_y;
      prod_s = front_ff.side * front_ff.side;
      square_in.sq_x    = prod_x[SQ_W-1:0];
      square_in.sq_y    = prod_y[SQ_W-1:0];
      square_in.side_sq = prod_s[SQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_ready[ST_SQUARE]) square_ff <= square_in;
   end

   // ------------------------------------------------------------------
   // sum: s = dx^2 + dy^2, den = 2 side^2, clamp s to den
   // ------------------------------------------------------------------
   div_type          sum_ff;
   div_type          sum_in;
   logic [DIV_W-1:0] dist_sq;

   always_comb begin
      dist_sq    = {1'b0, square_ff.sq_x} + {1'b0, square_ff.sq_y};
      sum_in.den = {square_ff.side_sq, 1'b0};
      sum_in.rem = (dist_sq > sum_in.den) ? sum_in.den : dist_sq;
      sum_in.quo = '0;
   end

   always_ff @(posedge clock) begin
      if (stage_ready[ST_SUM]) sum_ff <= sum_in;
   end

   // ------------------------------------------------------------------
   // divider: q = floor(s * 2^32 / den), up to four quotient bits a stage
   // ------------------------------------------------------------------
   div_type div_ff [DIV_STAGES];

   for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
      div_type div_src;
      div_type div_in;

      if (d == 0) begin : g_first
         assign div_src = sum_ff;
      end else begin : g_next
         assign div_src = div_ff[d-1];
      end

      assign div_in = div_steps(div_src, d * DIV_PER_STAGE);

      always_ff @(posedge clock) begin
         if (stage_ready[ST_DIV0+d]) div_ff[d] <= div_in;
      end
   end

   // ------------------------------------------------------------------
   // square root: r = floor(sqrt(q)), the ratio in Q0.16
   // ------------------------------------------------------------------
   sqrt_type sqrt_ff [SQRT_STAGES];

   for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
      sqrt_type sqrt_src;
      sqrt_type sqrt_in;

      if (g == 0) begin : g_first
         assign sqrt_src.rad  = {1'b0, div_ff[DIV_STAGES-1].quo};
         assign sqrt_src.rem  = '0;
         assign sqrt_src.root = '0;
      end else begin : g_next
         assign sqrt_src = sqrt_ff[g-1];
      end

      assign sqrt_in = sqrt_steps(sqrt_src, g * SQRT_PER_STAGE);

      always_ff @(posedge clock) begin
         if (stage_ready[ST_SQRT0+g]) sqrt_ff[g] <= sqrt_in;
      end
   end

   // ------------------------------------------------------------------
   // falloff: (1 - r)^10 by squarings, truncated to Q0.16 after each
   // ------------------------------------------------------------------
   localparam logic [QONE_W-1:0] QONE = QONE_W'(1) << FRAC_W;

   logic [QONE_W-1:0]   root_sat;
   logic [QONE_W-1:0]   a1;
   logic [2*QONE_W-1:0] prod_a2;
   logic [2*QONE_W-1:0] prod_a4;
   logic [2*QONE_W-1:0] prod_a8;
   logic [2*QONE_W-1:0] prod_a10;
   logic [QONE_W-1:0]   a10_sat;
   logic [QONE_W+7:0]   prod_alpha;

   logic [QONE_W-1:0]   pw2_ff;
   power_type           pw4_ff;
   power_type           pw8_ff;
   logic [QONE_W-1:0]   pw10_ff;
   logic [ALPHA_W-1:0]  alpha_ff;

   always_comb begin
      root_sat = (sqrt_ff[SQRT_STAGES-1].root > QONE) ? QONE : sqrt_ff[SQRT_STAGES-1].root;
      a1       = QONE - root_sat;
      prod_a2  = a1 * a1;
      prod_a4  = pw2_ff * pw2_ff;
      prod_a8  = pw4_ff.pw * pw4_ff.pw;
      prod_a10 = pw8_ff.pw * pw8_ff.a2;
      // clamp to 1.0 before the scale to 0..255
      a10_sat  = (prod_a10[2*QONE_W-1:FRAC_W] > {1'b0, QONE})
               ? QONE : prod_a10[FRAC_W +: QONE_W];
      prod_alpha = pw10_ff * (QONE_W+8)'(255);
   end

   always_ff @(posedge clock) begin
      if (stage_ready[ST_PW2]) begin
         pw2_ff <= prod_a2[FRAC_W +: QONE_W];
      end
      if (stage_ready[ST_PW4]) begin
         pw4_ff.pw <= prod_a4[FRAC_W +: QONE_W];
         pw4_ff.a2 <= pw2_ff;
      end
      if (stage_ready[ST_PW8]) begin
         pw8_ff.pw <= prod_a8[FRAC_W +: QONE_W];
         pw8_ff.a2 <= pw4_ff.a2;
      end
      if (stage_ready[ST_PW10]) begin
         pw10_ff <= a10_sat;
      end
      if (stage_ready[ST_ALPHA]) begin
         alpha_ff <= prod_alpha[FRAC_W +: ALPHA_W];
      end
   end

   // ------------------------------------------------------------------
   // output: the last stage register drives the response channel
   // ------------------------------------------------------------------
   assign rsp_bus.valid = valid_ff[NUM_STAGES-1];
   assign rsp_bus.alpha = alpha_ff;

endmodule

// ----- tb/tb_radial_falloff_alpha_top.sv -----
`timescale 1ns / 1ps

// Testbench for the radial falloff alpha block. A behavioural predictor
// works out the alpha of every accepted pixel from the side that was last
// written, and a checker compares each alpha transaction against the
// oldest prediction. Directed pixels cover the centre, corners, clamping
// and side saturation; random phases then mix raster scans of small
// textures with scattered and out-of-range coordinates under three
// stall profiles.

module tb_radial_falloff_alpha_top;
   import rfa_pkg::*;

   // cycles with no transaction on any channel before the run is abandoned
   localparam int STALL_LIMIT = 4000;
   localparam int FLUSH_CYCLES = 30;

   logic clock;
   logic reset;

   rfa_req_if req_bus ();
   rfa_rsp_if rsp_bus ();
   rfa_csr_if csr_bus ();

   radial_falloff_alpha_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // predicted alpha values, oldest first
   logic [ALPHA_W-1:0] alpha_expected[$];
   // side as the block holds it after the last accepted write
   logic [SIDE_W-1:0]  side_shadow;

   int sender_idle_pct;
   int receiver_idle_pct;
   int error_count;
   int pixels_sent;
   int alphas_checked;
   int side_writes;
   int idle_cycles;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Expected alpha of one pixel: clamp side and coordinates, form the
   // squared distance in doubled coordinates, take the Q0.16 ratio and
   // raise its complement to the tenth power with a truncation per product.
   function automatic logic [ALPHA_W-1:0] predict_alpha(input logic [SIDE_W-1:0] side_reg,
                                                       input logic [COORD_W-1:0] px,
                                                       input logic [COORD_W-1:0] py);
      longint side;
      longint cx;
      longint cy;
      longint dx;
      longint dy;
      longint unsigned dist_sq;
      longint unsigned den;
      longint unsigned ratio_sq;
      longint unsigned root;
      longint unsigned trial;
      longint unsigned p1;
      longint unsigned p2;
      longint unsigned p4;
      longint unsigned p8;
      longint unsigned p10;
      side = side_reg;
      if (side == 0) begin
         side = 1;
      end
      if (side > MAX_SIDE) begin
         side = MAX_SIDE;
      end
      cx = (px >= side) ? side - 1 : px;
      cy = (py >= side) ? side - 1 : py;
      dx = 2 * cx - side;
      dy = 2 * cy - side;
      dist_sq = dx * dx + dy * dy;
      den = 2 * side * side;
      if (dist_sq > den) begin
         dist_sq = den;
      end
      // fits comfortably: dist_sq is below 2^26
      ratio_sq = (dist_sq << 32) / den;
      // greedy bitwise floor square root, root below 2^17
      root = 0;
      for (int b = 16; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= ratio_sq) begin
            root = trial;
         end
      end
      if (root > 65536) begin
         root = 65536;
      end
      p1 = 65536 - root;
      p2 = (p1 * p1) >> 16;
      p4 = (p2 * p2) >> 16;
      p8 = (p4 * p4) >> 16;
      p10 = (p8 * p2) >> 16;
      if (p10 > 65536) begin
         p10 = 65536;
      end
      return ALPHA_W'((p10 * 255) >> 16);
   endfunction

   // Receiver: decide ready for the next edge at each falling edge.
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   // Checker: compare each alpha transaction against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (alpha_expected.size() == 0) begin
            $error("alpha: unexpected transaction, actual %0d", rsp_bus.alpha);
            error_count++;
         end else begin
            if (rsp_bus.alpha !== alpha_expected[0]) begin
               $error("alpha mismatch: expected %0d, actual %0d",
                      alpha_expected[0], rsp_bus.alpha);
               error_count++;
            end
            void'(alpha_expected.pop_front());
            alphas_checked++;
         end
      end
   end

   // Watchdog: count cycles in which no channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_radial_falloff_alpha_top: errors");
            $finish;
         end
      end
   end

   // Send one pixel, with random idle cycles ahead of it. Enter and leave
   // at a falling edge; valid stays high on exit so back-to-back pixels
   // need no second assignment in one step.
   task automatic send_pixel(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.pixel_x <= px;
      req_bus.pixel_y <= py;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      alpha_expected.push_back(predict_alpha(side_shadow, px, py));
      pixels_sent++;
      @(negedge clock);
   endtask

   // Hold off the sender until every predicted alpha has been seen.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (alpha_expected.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Write the side once the pipeline is empty; advance the shadow on the
   // accepting edge.
   task automatic write_side(input logic [SIDE_W-1:0] value);
      drain_results();
      csr_bus.valid        <= 1'b1;
      csr_bus.texture_side <= value;
      do begin
         @(posedge clock);
      end while (!csr_bus.ready);
      side_shadow = value;
      side_writes++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Pixels against the reset side: centre, corners, clamping beyond it.
   task automatic test_reset_side();
      send_pixel(12'd128, 12'd128);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd255, 12'd255);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd0, 12'd4095);
      send_pixel(12'd255, 12'd0);
   endtask

   // Extreme sides: one pixel, zero side, saturation above the maximum,
   // the maximum itself and the smallest odd and even sides.
   task automatic test_side_extremes();
      write_side(13'd1);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      write_side(13'd0);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd1, 12'd1);
      write_side(13'h1FFF);
      send_pixel(12'd2048, 12'd2048);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd4095, 12'd0);
      write_side(13'd4096);
      send_pixel(12'd2048, 12'd2048);
      send_pixel(12'd2047, 12'd2047);
      send_pixel(12'd0, 12'd4095);
      write_side(13'd4097);
      send_pixel(12'd4095, 12'd4095);
      write_side(13'd2);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd1, 12'd1);
      send_pixel(12'd1, 12'd0);
      write_side(13'd3);
      send_pixel(12'd1, 12'd1);
      send_pixel(12'd2, 12'd2);
   endtask

   // Random traffic under one stall profile. Each block writes a fresh
   // side, then either scans a small texture in raster order or scatters
   // pixels, a fifth of them anywhere in the 12-bit range.
   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int item_count);
      int sent;
      int pick;
      int span;
      logic [SIDE_W-1:0] side;
      sent = 0;
      sender_idle_pct   = send_pct;
      receiver_idle_pct = recv_pct;
      while (sent < item_count) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            side = SIDE_W'($urandom_range(1, 12));
         end else if (pick < 70) begin
            side = SIDE_W'($urandom_range(1, 64));
         end else if (pick < 80) begin
            case ($urandom_range(0, 4))
               0: side = 13'd0;
               1: side = 13'd1;
               2: side = 13'd4095;
               3: side = 13'd4096;
               default: side = 13'h1FFF;
            endcase
         end else begin
            side = SIDE_W'($urandom_range(1, 8191));
         end
         write_side(side);
         span = (side == 0) ? 1 : ((side > MAX_SIDE) ? MAX_SIDE : int'(side));
         if (span <= 12 && $urandom_range(0, 3) != 0) begin
            for (int y = 0; y < span; y++) begin
               for (int x = 0; x < span; x++) begin
                  send_pixel(COORD_W'(x), COORD_W'(y));
                  sent++;
               end
            end
         end else begin
            repeat ($urandom_range(20, 60)) begin
               if ($urandom_range(0, 4) == 0) begin
                  send_pixel(COORD_W'($urandom), COORD_W'($urandom));
               end else begin
                  send_pixel(COORD_W'($urandom_range(0, span - 1)),
                             COORD_W'($urandom_range(0, span - 1)));
               end
               sent++;
            end
         end
      end
   endtask

   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.pixel_x      = '0;
      req_bus.pixel_y      = '0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.texture_side = '0;
      side_shadow          = SIDE_W'(SIDE_RESET);
      sender_idle_pct      = 6;
      receiver_idle_pct    = 85;
      error_count          = 0;
      pixels_sent          = 0;
      alphas_checked       = 0;
      side_writes          = 0;
      idle_cycles          = 0;

      // hold reset, release at a falling edge
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_side();
      test_side_extremes();
      test_random_traffic(6, 85, 350);
      test_random_traffic(85, 6, 350);
      test_random_traffic(0, 0, 350);

      drain_results();
      repeat (FLUSH_CYCLES) @(negedge clock);
      if (alpha_expected.size() != 0) begin
         $error("alpha: %0d predicted values never arrived", alpha_expected.size());
         error_count++;
      end

      $display("Covered %0d pixels and %0d alpha checks over %0d side writes,",
               pixels_sent, alphas_checked, side_writes);
      $display("sides from zero up to saturation, raster and scattered pixels, three stall mixes.");
      if (error_count == 0) begin
         $display("tb_radial_falloff_alpha_top: clean");
      end else begin
         $display("tb_radial_falloff_alpha_top: errors");
      end
      $finish;
   end

endmodule
